// ===== design/sidx_pkg.sv =====
// Shared types and constants for the segment index box parser.
// No dependencies; used by the parser top level and its checker.
package sidx_pkg;

   localparam int unsigned HEADER_BYTES = 12;
   localparam logic [30:0] SIZE_MASK    = 31'h7FFF_FFFF;

   localparam int unsigned CSR_INDEX_WIDTH = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BOX_VERSION      = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PAYLOAD_POSITION = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BOX_SIZE         = 2'd2;

   localparam logic RESULT_HEADER   = 1'b0;
   localparam logic RESULT_FRAGMENT = 1'b1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_of_box;
   } req_payload_type;

   typedef struct packed {
      logic        result_kind;
      logic [31:0] reference_id;
      logic [31:0] timescale;
      logic [63:0] earliest_time;
      logic [15:0] fragment_count;
      logic [15:0] fragment_index;
      logic [63:0] fragment_offset;
      logic [30:0] fragment_size;
      logic [63:0] fragment_start;
      logic [31:0] fragment_duration;
      logic [63:0] total_end_time;
      logic        last;
   } rsp_payload_type;

endpackage

// ===== design/segment_index_box_parser.sv =====
// A byte that completes a result passes from the input register into the result register, which drives rsp_valid.
// Throughput: one byte per cycle; a stalled result holds the next byte in the
// input register, and a further byte is then stalled at the input.
// The absolute offset base is registered from the configuration registers in the cycle after a csr write.
// Synchronous active-high reset returns the parser to waiting for a start byte
// and empties both registers.
module segment_index_box_parser
   import sidx_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_payload_type            req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_payload_type            rsp_data,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [63:0]                csr_write_data
);

   typedef enum logic [3:0] {
      PH_WAIT, PH_REF, PH_SCALE, PH_EARLY, PH_FIRST, PH_RSV, PH_COUNT,
      PH_ESIZE, PH_EDUR, PH_EFLAGS, PH_DONE
   } phase_type;

   // configuration
   logic        box_version_ff;
   logic [63:0] payload_position_ff;
   logic [31:0] box_size_ff;
   logic [63:0] offset_base_ff;

   // channel registers
   logic            s1_valid_ff, s1_valid_in;
   req_payload_type s1_data_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   // parser state
   phase_type   phase_ff, phase_in;
   logic [2:0]  bif_ff, bif_in;
   logic [63:0] shifter_ff, shifter_in;
   logic [31:0] reference_ff, reference_in;
   logic [31:0] timescale_ff, timescale_in;
   logic [63:0] earliest_ff, earliest_in;
   logic [63:0] run_offset_ff, run_offset_in;
   logic [63:0] run_time_ff, run_time_in;
   logic [15:0] declared_ff, declared_in;
   logic [15:0] counter_ff, counter_in;
   logic [30:0] size_hold_ff, size_hold_in;
   logic [31:0] dur_hold_ff, dur_hold_in;

   logic        out_free, s1_fire, req_accept;
   phase_type   phase_cur;
   logic [2:0]  bif_cur;
   logic [63:0] shifter_cur, shifted, field_value, time_sum;
   logic [15:0] counter_cur;
   logic [3:0]  field_len;
   logic        field_done, fin;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_fire    = s1_valid_ff && out_free;
   assign req_stall  = s1_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // a start byte restarts the parse on this very byte
   always_comb begin
      phase_cur   = s1_data_ff.start_of_box ? PH_REF : phase_ff;
      bif_cur     = s1_data_ff.start_of_box ? 3'd0 : bif_ff;
      shifter_cur = s1_data_ff.start_of_box ? 64'd0 : shifter_ff;
      counter_cur = s1_data_ff.start_of_box ? 16'd0 : counter_ff;
      shifted     = {shifter_cur[55:0], s1_data_ff.data_byte};
      case (phase_cur)
         PH_EARLY, PH_FIRST: field_len = box_version_ff ? 4'd8 : 4'd4;
         PH_RSV, PH_COUNT:   field_len = 4'd2;
         default:            field_len = 4'd4;
      endcase
      field_done = ({1'b0, bif_cur} + 4'd1) >= field_len;
      case (field_len)
         4'd8:    field_value = shifted;
         4'd2:    field_value = {48'd0, shifted[15:0]};
         default: field_value = {32'd0, shifted[31:0]};
      endcase
      fin      = ({1'b0, counter_cur} + 17'd1) >= {1'b0, declared_ff};
      time_sum = run_time_ff + {32'd0, dur_hold_ff};
   end

   always_comb begin
      phase_in      = phase_ff;
      bif_in        = bif_ff;
      shifter_in    = shifter_ff;
      reference_in  = reference_ff;
      timescale_in  = timescale_ff;
      earliest_in   = earliest_ff;
      run_offset_in = run_offset_ff;
      run_time_in   = run_time_ff;
      declared_in   = declared_ff;
      counter_in    = counter_ff;
      size_hold_in  = size_hold_ff;
      dur_hold_in   = dur_hold_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      s1_valid_in   = req_accept || (s1_valid_ff && !s1_fire);

      if (s1_fire) begin
         phase_in   = phase_cur;
         bif_in     = bif_cur;
         shifter_in = shifter_cur;
         counter_in = counter_cur;
         if (phase_cur != PH_WAIT && phase_cur != PH_DONE) begin
            if (!field_done) begin
               shifter_in = shifted;
               bif_in     = bif_cur + 3'd1;
            end else begin
               shifter_in = 64'd0;
               bif_in     = 3'd0;
               unique case (phase_cur)
                  PH_REF: begin
                     reference_in = field_value[31:0];
                     phase_in     = PH_SCALE;
                  end
                  PH_SCALE: begin
                     timescale_in = field_value[31:0];
                     phase_in     = PH_EARLY;
                  end
                  PH_EARLY: begin
                     earliest_in = field_value;
                     run_time_in = field_value;
                     phase_in    = PH_FIRST;
                  end
                  PH_FIRST: begin
                     run_offset_in = field_value + offset_base_ff;
                     phase_in      = PH_RSV;
                  end
                  PH_RSV: begin
                     phase_in = PH_COUNT;
                  end
                  PH_COUNT: begin
                     declared_in  = field_value[15:0];
                     counter_in   = 16'd0;
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '{
                        result_kind:       RESULT_HEADER,
                        reference_id:      reference_ff,
                        timescale:         timescale_ff,
                        earliest_time:     earliest_ff,
                        fragment_count:    field_value[15:0],
                        fragment_index:    16'd0,
                        fragment_offset:   run_offset_ff,
                        fragment_size:     31'd0,
                        fragment_start:    64'd0,
                        fragment_duration: 32'd0,
                        total_end_time:    run_time_ff,
                        last:              (field_value[15:0] == 16'd0)
                     };
                     phase_in = (field_value[15:0] == 16'd0) ? PH_DONE : PH_ESIZE;
                  end
                  PH_ESIZE: begin
                     size_hold_in = field_value[30:0] & SIZE_MASK;
                     phase_in     = PH_EDUR;
                  end
                  PH_EDUR: begin
                     dur_hold_in = field_value[31:0];
                     phase_in    = PH_EFLAGS;
                  end
                  PH_EFLAGS: begin
                     rsp_valid_in  = 1'b1;
                     rsp_data_in   = '{
                        result_kind:       RESULT_FRAGMENT,
                        reference_id:      reference_ff,
                        timescale:         timescale_ff,
                        earliest_time:     earliest_ff,
                        fragment_count:    declared_ff,
                        fragment_index:    counter_cur,
                        fragment_offset:   run_offset_ff,
                        fragment_size:     size_hold_ff,
                        fragment_start:    run_time_ff,
                        fragment_duration: dur_hold_ff,
                        total_end_time:    time_sum,
                        last:              fin
                     };
                     run_time_in   = time_sum;
                     run_offset_in = run_offset_ff + {33'd0, size_hold_ff};
                     counter_in    = counter_cur + 16'd1;
                     phase_in      = fin ? PH_DONE : PH_ESIZE;
                  end
                  default: begin
                     phase_in = phase_cur;
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_version_ff      <= 1'b0;
         payload_position_ff <= 64'd0;
         box_size_ff         <= 32'd0;
         offset_base_ff      <= 64'd0;
         s1_valid_ff         <= 1'b0;
         rsp_valid_ff        <= 1'b0;
         phase_ff            <= PH_WAIT;
         bif_ff              <= 3'd0;
         shifter_ff          <= 64'd0;
         reference_ff        <= 32'd0;
         timescale_ff        <= 32'd0;
         earliest_ff         <= 64'd0;
         run_offset_ff       <= 64'd0;
         run_time_ff         <= 64'd0;
         declared_ff         <= 16'd0;
         counter_ff          <= 16'd0;
         size_hold_ff        <= 31'd0;
         dur_hold_ff         <= 32'd0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_BOX_VERSION:      box_version_ff      <= csr_write_data[0];
               CSR_PAYLOAD_POSITION: payload_position_ff <= csr_write_data;
               CSR_BOX_SIZE:         box_size_ff         <= csr_write_data[31:0];
               default:              box_size_ff         <= box_size_ff;
            endcase
         end
         // end of box relative to the stream, minus the full box header
         offset_base_ff <= payload_position_ff + {32'd0, box_size_ff}
                           - 64'(HEADER_BYTES);
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         phase_ff      <= phase_in;
         bif_ff        <= bif_in;
         shifter_ff    <= shifter_in;
         reference_ff  <= reference_in;
         timescale_ff  <= timescale_in;
         earliest_ff   <= earliest_in;
         run_offset_ff <= run_offset_in;
         run_time_ff   <= run_time_in;
         declared_ff   <= declared_in;
         counter_ff    <= counter_in;
         size_hold_ff  <= size_hold_in;
         dur_hold_ff   <= dur_hold_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_data_ff <= req_data;
      end
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== design/sidx_checker.sv =====
// Port-level checks for the segment index box parser, bound to its top level.
// Depends on sidx_pkg for the payload types and result kind codes.
module sidx_checker
   import sidx_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_data
);

   // a stalled result transfer holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_header_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind == RESULT_HEADER |->
         rsp_data.fragment_index == 16'd0 && rsp_data.fragment_size == 31'd0
         && rsp_data.fragment_start == 64'd0 && rsp_data.fragment_duration == 32'd0
         && rsp_data.last == (rsp_data.fragment_count == 16'd0))
      else $error("header result fields inconsistent");

   a_fragment_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind == RESULT_FRAGMENT |->
         rsp_data.total_end_time ==
            rsp_data.fragment_start + {32'd0, rsp_data.fragment_duration})
      else $error("fragment end time is not start plus duration");

endmodule

bind segment_index_box_parser sidx_checker u_sidx_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== tb/tb.sv =====
// Self-checking bench for segment_index_box_parser: drives sidx payload bytes and
// checks each header and fragment transfer against an in-bench parser model.
// Depends on sidx_pkg and the segment_index_box_parser top level.
module tb;
   import sidx_pkg::*;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int DRAIN_CYCLES    = 6;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 2'd3;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_REF_ID,
      PH_TIMESCALE,
      PH_EARLIEST,
      PH_BASE_OFFSET,
      PH_RESERVED,
      PH_ENTRY_COUNT,
      PH_REF_SIZE,
      PH_REF_DURATION,
      PH_SAP_FLAGS,
      PH_FINISHED
   } sidx_phase_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   req_payload_type            req_data = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   rsp_payload_type            rsp_data;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [63:0]                csr_write_data = '0;

   // register shadows
   logic        cfg_version  = 1'b0;
   logic [63:0] cfg_position = '0;
   logic [31:0] cfg_box_size = '0;

   // parser model state
   sidx_phase_type sidx_phase  = PH_IDLE;
   int          sidx_byte_pos  = 0;
   logic [63:0] sidx_shifter   = '0;
   logic [31:0] sidx_reference = '0;
   logic [31:0] sidx_scale     = '0;
   logic [63:0] sidx_earliest  = '0;
   logic [63:0] sidx_offset    = '0;
   logic [63:0] sidx_time      = '0;
   logic [15:0] sidx_declared  = '0;
   logic [15:0] sidx_entry     = '0;
   logic [30:0] sidx_size      = '0;
   logic [31:0] sidx_duration  = '0;

   rsp_payload_type pending_sidx_results[$];
   int unsigned     bytes_parsed   = 0;
   int              mismatch_count = 0;
   int              cycle_count    = 0;
   int              send_idle_pct  = 0;
   int              recv_stall_pct = 0;
   int              hold_off_left  = 0;

   segment_index_box_parser u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic int field_bytes(input sidx_phase_type phase);
      if (phase == PH_EARLIEST || phase == PH_BASE_OFFSET)
         return cfg_version ? 8 : 4;
      if (phase == PH_RESERVED || phase == PH_ENTRY_COUNT)
         return 2;
      return 4;
   endfunction

   // advance the parser model by one accepted byte, queue any result it yields
   function automatic void parse_sidx_byte(input req_payload_type item);
      int              len;
      logic [63:0]     value;
      rsp_payload_type res;
      if (item.start_of_box) begin
         sidx_phase    = PH_REF_ID;
         sidx_byte_pos = 0;
         sidx_shifter  = '0;
         sidx_entry    = '0;
      end
      if (sidx_phase == PH_IDLE || sidx_phase == PH_FINISHED)
         return;
      bytes_parsed++;
      sidx_shifter = {sidx_shifter[55:0], item.data_byte};
      len = field_bytes(sidx_phase);
      if (sidx_byte_pos + 1 < len) begin
         sidx_byte_pos++;
         return;
      end
      value = (len == 8) ? sidx_shifter : sidx_shifter & ((64'd1 << (8 * len)) - 64'd1);
      sidx_byte_pos = 0;
      sidx_shifter  = '0;
      res = '0;
      res.reference_id   = sidx_reference;
      res.timescale      = sidx_scale;
      res.earliest_time  = sidx_earliest;
      case (sidx_phase)
         PH_REF_ID: begin
            sidx_reference = value[31:0];
            sidx_phase = PH_TIMESCALE;
         end
         PH_TIMESCALE: begin
            sidx_scale = value[31:0];
            sidx_phase = PH_EARLIEST;
         end
         PH_EARLIEST: begin
            sidx_earliest = value;
            sidx_time     = value;
            sidx_phase    = PH_BASE_OFFSET;
         end
         PH_BASE_OFFSET: begin
            sidx_offset = value + cfg_position + {32'h0, cfg_box_size} - 64'(HEADER_BYTES);
            sidx_phase  = PH_RESERVED;
         end
         PH_RESERVED: begin
            sidx_phase = PH_ENTRY_COUNT;
         end
         PH_ENTRY_COUNT: begin
            sidx_declared = value[15:0];
            sidx_entry    = '0;
            res.result_kind     = RESULT_HEADER;
            res.fragment_count  = sidx_declared;
            res.fragment_offset = sidx_offset;
            res.total_end_time  = sidx_time;
            res.last            = (sidx_declared == 16'd0);
            pending_sidx_results.push_back(res);
            sidx_phase = (sidx_declared != 16'd0) ? PH_REF_SIZE : PH_FINISHED;
         end
         PH_REF_SIZE: begin
            sidx_size  = value[30:0];
            sidx_phase = PH_REF_DURATION;
         end
         PH_REF_DURATION: begin
            sidx_duration = value[31:0];
            sidx_phase    = PH_SAP_FLAGS;
         end
         default: begin
            res.result_kind       = RESULT_FRAGMENT;
            res.fragment_count    = sidx_declared;
            res.fragment_index    = sidx_entry;
            res.fragment_offset   = sidx_offset;
            res.fragment_size     = sidx_size;
            res.fragment_start    = sidx_time;
            res.fragment_duration = sidx_duration;
            sidx_time             = sidx_time + {32'h0, sidx_duration};
            res.total_end_time    = sidx_time;
            res.last              = (32'(sidx_entry) + 1 >= 32'(sidx_declared));
            pending_sidx_results.push_back(res);
            sidx_offset = sidx_offset + {33'h0, sidx_size};
            sidx_entry  = sidx_entry + 16'd1;
            sidx_phase  = res.last ? PH_FINISHED : PH_REF_SIZE;
         end
      endcase
   endfunction

   function automatic void check_field(input string field, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         mismatch_count++;
      end
   endfunction

   function automatic void compare_result(input rsp_payload_type got);
      rsp_payload_type want;
      if (pending_sidx_results.size() == 0) begin
         $error("result transfer with no expected result pending");
         mismatch_count++;
         return;
      end
      want = pending_sidx_results.pop_front();
      check_field("result_kind", 64'(want.result_kind), 64'(got.result_kind));
      check_field("reference_id", 64'(want.reference_id), 64'(got.reference_id));
      check_field("timescale", 64'(want.timescale), 64'(got.timescale));
      check_field("earliest_time", want.earliest_time, got.earliest_time);
      check_field("fragment_count", 64'(want.fragment_count), 64'(got.fragment_count));
      check_field("fragment_index", 64'(want.fragment_index), 64'(got.fragment_index));
      check_field("fragment_offset", want.fragment_offset, got.fragment_offset);
      check_field("fragment_size", 64'(want.fragment_size), 64'(got.fragment_size));
      check_field("fragment_start", want.fragment_start, got.fragment_start);
      check_field("fragment_duration", 64'(want.fragment_duration),
                  64'(got.fragment_duration));
      check_field("total_end_time", want.total_end_time, got.total_end_time);
      check_field("last", 64'(want.last), 64'(got.last));
   endfunction

   // result side: check each transfer, then pick the next stall value
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         compare_result(rsp_data);
      if (hold_off_left > 0) begin
         rsp_stall <= 1'b1;
         hold_off_left = hold_off_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // valid stays high after a transfer; whoever pauses the stream lowers it
   task automatic send_byte(input logic [7:0] data, input logic start);
      req_payload_type item;
      item.data_byte    = data;
      item.start_of_box = start;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      parse_sidx_byte(item);
   endtask

   task automatic send_field(input logic [63:0] value, input int nbytes, input logic start);
      for (int i = nbytes - 1; i >= 0; i--)
         send_byte(value[8*i +: 8], start && (i == nbytes - 1));
   endtask

   function automatic logic [31:0] pick32(input bit vary);
      if (vary)
         return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      return $urandom;
   endfunction

   function automatic logic [63:0] pick64(input bit vary);
      if (vary)
         return $urandom_range(1) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0;
      return {$urandom, $urandom};
   endfunction

   // time and offset widths follow the version register at call time
   task automatic send_box(input logic [31:0] ref_id, input logic [31:0] scale,
                           input logic [63:0] earliest, input logic [63:0] rel_offset,
                           input logic [15:0] count, input int entries, input bit vary);
      int time_bytes;
      time_bytes = cfg_version ? 8 : 4;
      send_field({32'h0, ref_id}, 4, 1'b1);
      send_field({32'h0, scale}, 4, 1'b0);
      send_field(earliest, time_bytes, 1'b0);
      send_field(rel_offset, time_bytes, 1'b0);
      send_field(64'($urandom), 2, 1'b0);
      send_field({48'h0, count}, 2, 1'b0);
      repeat (entries) begin
         send_field({32'h0, pick32(vary)}, 4, 1'b0);
         send_field({32'h0, pick32(vary)}, 4, 1'b0);
         send_field(64'($urandom), 4, 1'b0);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_sidx_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] index,
                                 input logic [63:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (index)
         CSR_BOX_VERSION:      cfg_version  = value[0];
         CSR_PAYLOAD_POSITION: cfg_position = value;
         CSR_BOX_SIZE:         cfg_box_size = value[31:0];
         default: ;
      endcase
      // offset base is registered in the cycle after the write
      repeat (2) @(posedge clock);
   endtask

   task automatic test_ignored_bytes();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hA5, 1'b0);
      wait_idle();
      write_register(CSR_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
   endtask

   task automatic test_wide_extremes();
      write_register(CSR_BOX_VERSION, 64'd1);
      write_register(CSR_PAYLOAD_POSITION, 64'hFFFF_FFFF_FFFF_FFFF);
      write_register(CSR_BOX_SIZE, 64'hFFFF_FFFF);
      send_box(32'hFFFF_FFFF, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
               16'd2, 2, 1'b1);
      wait_idle();
   endtask

   task automatic test_narrow_wrap();
      write_register(CSR_BOX_VERSION, 64'hFFFF_FFFF_FFFF_FFFE);
      write_register(CSR_PAYLOAD_POSITION, 64'h0);
      write_register(CSR_BOX_SIZE, 64'h0);
      // zero relative offset with a zero base wraps below zero
      send_box(32'h0, 32'hFFFF_FFFF, 64'hFFFF_FFFF, 64'h0, 16'd1, 1, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      wait_idle();
   endtask

   task automatic test_restart_and_empty();
      send_field(64'($urandom), 4, 1'b1);
      send_field(64'($urandom), 3, 1'b0);
      send_box($urandom, $urandom, pick64(0), pick64(0), 16'd0, 0, 1'b0);
      send_byte(8'h5A, 1'b0);
      send_byte(8'hC3, 1'b0);
      wait_idle();
   endtask

   task automatic test_config_mid_box();
      write_register(CSR_BOX_VERSION, 64'd1);
      send_field(64'($urandom), 4, 1'b1);
      send_field(64'($urandom), 4, 1'b0);
      send_field(64'($urandom), 3, 1'b0);
      wait_idle();
      // narrowing mid-field closes the earliest time at four bytes
      write_register(CSR_BOX_VERSION, 64'd0);
      send_byte(8'($urandom), 1'b0);
      send_field(64'($urandom), 3, 1'b0);
      wait_idle();
      write_register(CSR_PAYLOAD_POSITION, pick64(0));
      write_register(CSR_BOX_SIZE, {32'h0, pick32(0)});
      send_byte(8'($urandom), 1'b0);
      send_field(64'($urandom), 2, 1'b0);
      send_field(64'd1, 2, 1'b0);
      repeat (3) send_field(64'($urandom), 4, 1'b0);
      wait_idle();
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct, input int goal);
      int          choice;
      int unsigned mark;
      logic [15:0] count;
      int          sent;
      bit          vary;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      mark = bytes_parsed;
      while (bytes_parsed - mark < goal) begin
         choice = $urandom_range(99);
         vary   = ($urandom_range(7) == 0);
         if (choice < 12) begin
            wait_idle();
            write_register(CSR_BOX_VERSION, {$urandom, $urandom});
            write_register(CSR_PAYLOAD_POSITION, pick64(vary));
            write_register(CSR_BOX_SIZE, {32'h0, pick32(vary)});
            if ($urandom_range(3) == 0)
               write_register(CSR_UNUSED, {$urandom, $urandom});
         end else if (choice < 78) begin
            count = 16'($urandom_range(5));
            send_box(pick32(vary), pick32(vary), pick64(vary), pick64(vary), count,
                     int'(count), vary);
         end else if (choice < 90) begin
            // declared count no smaller than what arrives before the next start
            count = vary ? 16'hFFFF : 16'($urandom);
            sent  = $urandom_range(3);
            if (sent > int'(count))
               sent = int'(count);
            send_box(pick32(vary), pick32(vary), pick64(vary), pick64(vary), count, sent, vary);
         end else begin
            repeat ($urandom_range(1, 16))
               send_byte(8'($urandom), $urandom_range(7) == 0);
         end
         if ($urandom_range(4) == 0)
            repeat ($urandom_range(1, 4))
               send_byte(8'($urandom), 1'b0);
      end
      wait_idle();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      hold_off_left = HOLD_OFF_CYCLES;
      send_box($urandom, $urandom, pick64(0), pick64(0), 16'd24, 24, 1'b0);
      wait_idle();
   endtask

   initial begin
      send_idle_pct  = 38;
      recv_stall_pct = 59;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_ignored_bytes();
      test_wide_extremes();
      test_narrow_wrap();
      test_restart_and_empty();
      test_config_mid_box();
      test_random_traffic(38, 59, 350);
      test_random_traffic(59, 38, 350);
      test_random_traffic(0, 0, 350);
      test_backpressure();
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
